// ----- rtl/core/json_string_unescape_utf8_assert.svh -----
// assertion macros shared by the unescaper modules
// expects signals named clock and reset in the including module
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_IMPL(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- rtl/core/jsu_pkg.sv -----
// shared types and constants for the json string unescaper
// no dependencies
package jsu_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // result status codes
   localparam logic [2:0] STAT_DATA    = 3'd0;
   localparam logic [2:0] STAT_END     = 3'd1;
   localparam logic [2:0] STAT_CTRL    = 3'd2;
   localparam logic [2:0] STAT_BAD_ESC = 3'd3;
   localparam logic [2:0] STAT_BAD_HEX = 3'd4;
   localparam logic [2:0] STAT_UNTERM  = 3'd5;

   // one decoded input item: up to four results, status only on the final one
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic [2:0]      status;
   } cmd_type;

endpackage

// ----- rtl/core/json_string_unescape_utf8.sv -----
// JSON string body unescaper with UTF-8 output. Takes one body byte per transfer
// (after the opening quote) and one transfer per clock; each byte yields zero to
// four result transfers (escaped code points become UTF-8, a surrogate pair one
// 4-byte sequence, a closing quote or an error ends the string with its status and
// re-arms). Results leave at one per clock while rsp_tready is high, through a four-entry
// command queue; input stalls only while that queue is full, which happens when
// multi-byte results arrive faster than the output drains them. Results pass
// through the command queue and then the output register.
// depends on jsu_pkg, jsu_front, jsu_cmd_queue, jsu_back
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tuser,   // req_type
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [3:0] rsp_tuser,   // byte_valid, status[2:0]
   output logic       rsp_tlast    // last
);

   logic             q_full;
   logic             push;
   jsu_pkg::cmd_type push_cmd;
   logic             pop;
   logic             head_valid;
   jsu_pkg::cmd_type head_cmd;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   jsu_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/jsu_front.sv -----
// front end: accepts body bytes, tracks escape state, builds result commands
// depends on jsu_pkg and json_string_unescape_utf8_assert.svh
`include "json_string_unescape_utf8_assert.svh"

module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // in_byte
   input  logic               req_tuser,   // req_type (1 = end of text)
   input  logic               q_full,
   output logic               push,
   output jsu_pkg::cmd_type   push_cmd
);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_N     = 8'h6E;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CTRL_MAX   = 8'h1F;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [11:0] hex_acc_ff, hex_acc_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_code_ff, pend_code_in;

   logic            accept;
   logic [3:0][7:0] fl_bytes;
   logic [1:0]      fl_cnt;
   logic            hex_ok;
   logic [3:0]      hex_val;
   logic            esc_ok;
   logic [7:0]      esc_byte;
   logic [15:0]     cp;
   logic            is_pair;
   logic [20:0]     full_cp;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // utf-8 bytes of the held code point
   always_comb begin
      fl_bytes = '0;
      fl_cnt   = 2'd0;
      if (pend_valid_ff) begin
         if (pend_code_ff < 16'h0080) begin
            fl_bytes[0] = pend_code_ff[7:0];
            fl_cnt      = 2'd1;
         end else if (pend_code_ff < 16'h0800) begin
            fl_bytes[0] = {3'b110, pend_code_ff[10:6]};
            fl_bytes[1] = {2'b10, pend_code_ff[5:0]};
            fl_cnt      = 2'd2;
         end else begin
            fl_bytes[0] = {4'b1110, pend_code_ff[15:12]};
            fl_bytes[1] = {2'b10, pend_code_ff[11:6]};
            fl_bytes[2] = {2'b10, pend_code_ff[5:0]};
            fl_cnt      = 2'd3;
         end
      end
   end

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
         hex_val = 4'(req_tdata - 8'h30);
      end else if (req_tdata >= 8'h61 && req_tdata <= 8'h66) begin
         hex_val = 4'(req_tdata - 8'h57);
      end else if (req_tdata >= 8'h41 && req_tdata <= 8'h46) begin
         hex_val = 4'(req_tdata - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      esc_ok   = 1'b1;
      esc_byte = req_tdata;
      unique case (req_tdata)
         CHAR_B: esc_byte = 8'h08;
         CHAR_F: esc_byte = 8'h0C;
         CHAR_N: esc_byte = 8'h0A;
         CHAR_R: esc_byte = 8'h0D;
         CHAR_T: esc_byte = 8'h09;
         CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: esc_byte = req_tdata;
         default: esc_ok = 1'b0;
      endcase
   end

   assign cp      = {hex_acc_ff, hex_val};
   assign is_pair = pend_valid_ff && (pend_code_ff[15:10] == 6'b110110)
                    && (cp[15:10] == 6'b110111);
   assign full_cp = {1'b0, pend_code_ff[9:0], cp[9:0]} + 21'h10000;

   always_comb begin
      mode_in       = mode_ff;
      hex_cnt_in    = hex_cnt_ff;
      hex_acc_in    = hex_acc_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      push          = 1'b0;
      push_cmd      = '0;
      if (accept) begin
         unique case (mode_ff)
            MODE_ESC: begin
               if (req_tuser || !(esc_ok || req_tdata == CHAR_U)) begin
                  push            = 1'b1;
                  push_cmd.status = jsu_pkg::STAT_BAD_ESC;
               end else if (req_tdata == CHAR_U) begin
                  mode_in    = MODE_HEX;
                  hex_cnt_in = 2'd0;
                  hex_acc_in = '0;
               end else begin
                  push                      = 1'b1;
                  push_cmd.bytes            = fl_bytes;
                  push_cmd.bytes[fl_cnt]    = esc_byte;
                  push_cmd.last_idx         = fl_cnt;
                  pend_valid_in             = 1'b0;
                  pend_code_in              = '0;
                  mode_in                   = MODE_NORMAL;
               end
            end
            MODE_HEX: begin
               if (req_tuser || !hex_ok) begin
                  push            = 1'b1;
                  push_cmd.status = jsu_pkg::STAT_BAD_HEX;
               end else if (hex_cnt_ff == 2'd3) begin
                  if (is_pair) begin
                     push              = 1'b1;
                     push_cmd.bytes[0] = {5'b11110, full_cp[20:18]};
                     push_cmd.bytes[1] = {2'b10, full_cp[17:12]};
                     push_cmd.bytes[2] = {2'b10, full_cp[11:6]};
                     push_cmd.bytes[3] = {2'b10, full_cp[5:0]};
                     push_cmd.last_idx = 2'd3;
                     pend_valid_in     = 1'b0;
                     pend_code_in      = '0;
                  end else begin
                     // older code point leaves, the new one is held
                     push              = (fl_cnt != 2'd0);
                     push_cmd.bytes    = fl_bytes;
                     push_cmd.last_idx = fl_cnt - 2'd1;
                     pend_valid_in     = 1'b1;
                     pend_code_in      = cp;
                  end
                  mode_in    = MODE_NORMAL;
                  hex_cnt_in = 2'd0;
                  hex_acc_in = '0;
               end else begin
                  hex_acc_in = {hex_acc_ff[7:0], hex_val};
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end
            end
            default: begin
               if (req_tuser) begin
                  push            = 1'b1;
                  push_cmd.status = jsu_pkg::STAT_UNTERM;
               end else if (req_tdata == CHAR_QUOTE) begin
                  push              = 1'b1;
                  push_cmd.bytes    = fl_bytes;
                  push_cmd.last_idx = fl_cnt;
                  push_cmd.status   = jsu_pkg::STAT_END;
               end else if (req_tdata <= CTRL_MAX) begin
                  push            = 1'b1;
                  push_cmd.status = jsu_pkg::STAT_CTRL;
               end else if (req_tdata == CHAR_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  push                   = 1'b1;
                  push_cmd.bytes         = fl_bytes;
                  push_cmd.bytes[fl_cnt] = req_tdata;
                  push_cmd.last_idx      = fl_cnt;
                  pend_valid_in          = 1'b0;
                  pend_code_in           = '0;
                  mode_in                = MODE_NORMAL;
               end
            end
         endcase
         // end of string or error re-arms for the next body
         if (push_cmd.status != jsu_pkg::STAT_DATA) begin
            mode_in       = MODE_NORMAL;
            hex_cnt_in    = 2'd0;
            hex_acc_in    = '0;
            pend_valid_in = 1'b0;
            pend_code_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         hex_cnt_ff    <= 2'd0;
         hex_acc_ff    <= '0;
         pend_valid_ff <= 1'b0;
         pend_code_ff  <= '0;
      end else begin
         mode_ff       <= mode_in;
         hex_cnt_ff    <= hex_cnt_in;
         hex_acc_ff    <= hex_acc_in;
         pend_valid_ff <= pend_valid_in;
         pend_code_ff  <= pend_code_in;
      end
   end

   `JSU_ASSERT_NEXT(a_rearm_after_end, push && push_cmd.status != jsu_pkg::STAT_DATA,
      mode_ff == MODE_NORMAL && !pend_valid_ff, "state not re-armed after end or error")
   `JSU_ASSERT_IMPL(a_status_alone_on_error,
      push && push_cmd.status != jsu_pkg::STAT_DATA && push_cmd.status != jsu_pkg::STAT_END,
      push_cmd.last_idx == 2'd0, "error result preceded by data")
   `JSU_ASSERT_IMPL(a_push_needs_room, push, !q_full, "command pushed while the queue is full")

endmodule

// ----- rtl/core/jsu_cmd_queue.sv -----
// short command queue between the front and back ends
// depends on jsu_pkg and json_string_unescape_utf8_assert.svh
`include "json_string_unescape_utf8_assert.svh"

module jsu_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsu_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output jsu_pkg::cmd_type  head_cmd
);

   jsu_pkg::cmd_type ent_ff [jsu_pkg::QUEUE_DEPTH];

   logic [jsu_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + jsu_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + jsu_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + jsu_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - jsu_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `JSU_ASSERT_IMPL(a_no_overflow, push, !full, "transfer pushed into a full queue")
   `JSU_ASSERT_IMPL(a_no_underflow, pop, head_valid, "pop from an empty queue")
   `JSU_ASSERT_IMPL(a_count_bound, 1'b1,
      count_ff <= jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH), "queue count beyond depth")

endmodule

// ----- rtl/core/jsu_back.sv -----
// back end: walks the results of each queued command into the output register
// depends on jsu_pkg and json_string_unescape_utf8_assert.svh
`include "json_string_unescape_utf8_assert.svh"

module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  jsu_pkg::cmd_type  head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // out_byte
   output logic [3:0]        rsp_tuser,   // byte_valid, status[2:0]
   output logic              rsp_tlast    // last
);

   logic [1:0] sub_ff, sub_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       flag_ff, flag_in;
   logic [2:0] status_ff, status_in;
   logic       last_ff, last_in;

   logic load;
   logic slot_last;
   logic slot_stat;

   assign load      = head_valid && (!valid_ff || rsp_tready);
   assign slot_last = (sub_ff == head_cmd.last_idx);
   assign slot_stat = slot_last && (head_cmd.status != jsu_pkg::STAT_DATA);
   assign pop       = load && slot_last;

   always_comb begin
      sub_in    = sub_ff;
      valid_in  = valid_ff && !rsp_tready;
      byte_in   = byte_ff;
      flag_in   = flag_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (load) begin
         sub_in    = slot_last ? 2'd0 : sub_ff + 2'd1;
         valid_in  = 1'b1;
         byte_in   = slot_stat ? 8'd0 : head_cmd.bytes[sub_ff];
         flag_in   = !slot_stat;
         status_in = slot_last ? head_cmd.status : jsu_pkg::STAT_DATA;
         last_in   = slot_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      flag_ff   <= flag_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {status_ff, flag_ff};
   assign rsp_tlast  = last_ff;

   `JSU_ASSERT_IMPL(a_status_only_last, valid_ff && !last_ff,
      status_ff == jsu_pkg::STAT_DATA && flag_ff, "non-final result carries a status")
   // the rest of a command is still at the queue head, so no bubble inside a burst
   `JSU_ASSERT_NEXT(a_burst_continues, valid_ff && rsp_tready && !last_ff,
      valid_ff, "gap inside the results of one item")
   `JSU_ASSERT_IMPL(a_sub_in_range, head_valid, sub_ff <= head_cmd.last_idx,
      "result index past the end of the command")

endmodule

// ----- verif/utf8_result_checker.sv -----
// result checker for the json string unescaper: watches both stream channels,
// predicts the decoded bytes and end/error statuses and compares every result transfer
// depends on jsu_pkg
module utf8_result_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tuser,   // req_type
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // out_byte
   input  logic [3:0] rsp_tuser,   // byte_valid, status[2:0]
   input  logic       rsp_tlast,   // last
   output int         fail_count,
   output int         open_count
);

   localparam logic [1:0] MODE_BODY = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;
   localparam int         SHOW_MAX  = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic [2:0] status;
      logic       last;
   } rsp_item_type;

   // decoder copy
   logic [1:0]  dec_mode;
   logic [1:0]  hex_cnt;
   logic [15:0] hex_acc;
   logic        held_valid;
   logic [15:0] held_code;

   rsp_item_type burst[$];
   rsp_item_type decoded_q[$];
   rsp_item_type got_item;
   rsp_item_type want_item;

   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      return 5'd0;
   endfunction

   task automatic clear_decoder();
      dec_mode   = MODE_BODY;
      hex_cnt    = 2'd0;
      hex_acc    = 16'd0;
      held_valid = 1'b0;
      held_code  = 16'd0;
   endtask

   task automatic emit_result(input logic [7:0] d, input logic v, input logic [2:0] s);
      rsp_item_type it;
      it.data   = d;
      it.valid  = v;
      it.status = s;
      it.last   = 1'b0;
      burst = {burst, it};
   endtask

   task automatic emit_utf8(input logic [20:0] cp);
      if (cp < 21'h80) begin
         emit_result({1'b0, cp[6:0]}, 1'b1, jsu_pkg::STAT_DATA);
      end else if (cp < 21'h800) begin
         emit_result({3'b110, cp[10:6]}, 1'b1, jsu_pkg::STAT_DATA);
         emit_result({2'b10, cp[5:0]}, 1'b1, jsu_pkg::STAT_DATA);
      end else if (cp < 21'h10000) begin
         emit_result({4'b1110, cp[15:12]}, 1'b1, jsu_pkg::STAT_DATA);
         emit_result({2'b10, cp[11:6]}, 1'b1, jsu_pkg::STAT_DATA);
         emit_result({2'b10, cp[5:0]}, 1'b1, jsu_pkg::STAT_DATA);
      end else begin
         emit_result({5'b11110, cp[20:18]}, 1'b1, jsu_pkg::STAT_DATA);
         emit_result({2'b10, cp[17:12]}, 1'b1, jsu_pkg::STAT_DATA);
         emit_result({2'b10, cp[11:6]}, 1'b1, jsu_pkg::STAT_DATA);
         emit_result({2'b10, cp[5:0]}, 1'b1, jsu_pkg::STAT_DATA);
      end
   endtask

   task automatic flush_held();
      if (held_valid) emit_utf8({5'd0, held_code});
      held_valid = 1'b0;
      held_code  = 16'd0;
   endtask

   task automatic decode_item(input logic eot, input logic [7:0] b);
      logic        rearm;
      logic        simple;
      logic [7:0]  esc;
      logic [4:0]  nib;
      logic [15:0] cp;
      burst.delete();
      rearm  = 1'b0;
      simple = 1'b0;
      esc    = 8'd0;
      case (dec_mode)
         MODE_ESC: begin
            if (eot) begin
               rearm = 1'b1;
            end else begin
               simple = 1'b1;
               case (b)
                  "u": begin
                     simple   = 1'b0;
                     dec_mode = MODE_HEX;
                     hex_cnt  = 2'd0;
                     hex_acc  = 16'd0;
                  end
                  "b": esc = 8'h08;
                  "f": esc = 8'h0C;
                  "n": esc = 8'h0A;
                  "r": esc = 8'h0D;
                  "t": esc = 8'h09;
                  "\"", "\\", "/": esc = b;
                  default: begin
                     simple = 1'b0;
                     rearm  = 1'b1;
                  end
               endcase
            end
            if (rearm) emit_result(8'd0, 1'b0, jsu_pkg::STAT_BAD_ESC);
            if (simple) begin
               flush_held();
               emit_result(esc, 1'b1, jsu_pkg::STAT_DATA);
               dec_mode = MODE_BODY;
            end
         end
         MODE_HEX: begin
            nib = eot ? 5'd0 : hex_nibble(b);
            if (!nib[4]) begin
               emit_result(8'd0, 1'b0, jsu_pkg::STAT_BAD_HEX);
               rearm = 1'b1;
            end else begin
               hex_acc = {hex_acc[11:0], nib[3:0]};
               if (hex_cnt == 2'd3) begin
                  cp = hex_acc;
                  // high surrogate waiting and a low one arrives: one 4-byte sequence
                  if (held_valid && held_code >= 16'hD800 && held_code <= 16'hDBFF
                      && cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                     emit_utf8({1'b0, held_code[9:0], cp[9:0]} + 21'h10000);
                     held_valid = 1'b0;
                     held_code  = 16'd0;
                  end else begin
                     flush_held();
                     held_valid = 1'b1;
                     held_code  = cp;
                  end
                  dec_mode = MODE_BODY;
                  hex_cnt  = 2'd0;
                  hex_acc  = 16'd0;
               end else begin
                  hex_cnt = hex_cnt + 2'd1;
               end
            end
         end
         default: begin
            if (eot) begin
               emit_result(8'd0, 1'b0, jsu_pkg::STAT_UNTERM);
               rearm = 1'b1;
            end else if (b == "\"") begin
               flush_held();
               emit_result(8'd0, 1'b0, jsu_pkg::STAT_END);
               rearm = 1'b1;
            end else if (b <= 8'h1F) begin
               emit_result(8'd0, 1'b0, jsu_pkg::STAT_CTRL);
               rearm = 1'b1;
            end else if (b == "\\") begin
               dec_mode = MODE_ESC;
            end else begin
               flush_held();
               emit_result(b, 1'b1, jsu_pkg::STAT_DATA);
               dec_mode = MODE_BODY;
            end
         end
      endcase
      if (rearm) clear_decoder();
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      decoded_q = {decoded_q, burst};
   endtask

   task automatic note_failure(input logic known, input rsp_item_type want,
                               input rsp_item_type got);
      fail_count = fail_count + 1;
      if (fail_count <= SHOW_MAX) begin
         if (known)
            $display({"mismatch: expected data=%02h valid=%b status=%0d last=%b, ",
                      "got data=%02h valid=%b status=%0d last=%b"},
                     want.data, want.valid, want.status, want.last,
                     got.data, got.valid, got.status, got.last);
         else
            $display("unexpected transfer: data=%02h valid=%b status=%0d last=%b",
                     got.data, got.valid, got.status, got.last);
      end
   endtask

   initial begin
      fail_count = 0;
      open_count = 0;
      clear_decoder();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready) decode_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got_item.data   = rsp_tdata;
            got_item.valid  = rsp_tuser[0];
            got_item.status = rsp_tuser[3:1];
            got_item.last   = rsp_tlast;
            if (decoded_q.size() == 0) begin
               note_failure(1'b0, got_item, got_item);
            end else begin
               want_item = decoded_q.pop_front();
               if (got_item !== want_item) note_failure(1'b1, want_item, got_item);
            end
         end
      end
      open_count = decoded_q.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// top of the json string unescaper testbench: clock, reset, stream stimulus and verdict
// depends on jsu_pkg, json_string_unescape_utf8 and utf8_result_checker
module tb_top;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          ITEM_TARGET = 310;
   localparam int          STALL_AT    = 150;
   localparam int          QUIET_FROM  = 200;
   localparam int          QUIET_TO    = 260;
   localparam int          HOLD_CYCLES = 300;
   localparam int          TAIL_CYCLES = 16;
   // simple escape letters, one per byte
   localparam logic [63:0] ESC_SET     = {"bfnrt", "\"", "\\", "/"};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // in_byte
   logic       req_tuser = 1'b0;   // req_type
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // out_byte
   logic [3:0] rsp_tuser;          // byte_valid, status[2:0]
   logic       rsp_tlast;          // last

   logic       quiet = 1'b0;
   logic       stall_trigger = 1'b0;
   int         items_sent = 0;
   int         cycle_count = 0;
   int         fail_count;
   int         open_count;

   always #4 clock = ~clock;

   json_string_unescape_utf8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_result_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random back-pressure plus one long hold-off counted here
   initial begin : receiver
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_trigger && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
         end
      end
   end

   function automatic logic is_hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_escape_char(input logic [7:0] c);
      logic hit;
      hit = (c == "u");
      for (int i = 0; i < 8; i++) if (ESC_SET[8*i +: 8] == c) hit = 1'b1;
      return hit;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return "0" + {4'd0, n};
      return (upper ? "A" : "a") + {4'd0, n} - 8'd10;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input logic eot, input logic [7:0] b);
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= eot;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      items_sent = items_sent + 1;
      @(negedge clock);
   endtask

   // backslash, u, then the top digits of cp in random letter case
   task automatic send_ucode(input logic [15:0] cp, input int digits);
      send_item(1'b0, "\\");
      send_item(1'b0, "u");
      for (int i = 0; i < digits; i++)
         send_item(1'b0, hex_char(cp[15 - 4*i -: 4], 1'($urandom_range(0, 1))));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (open_count != 0) @(negedge clock);
   endtask

   task automatic send_body();
      int          count;
      int          pick;
      logic [7:0]  b;
      logic [15:0] cp;
      count = $urandom_range(0, 6);
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2: begin
               do b = 8'($urandom_range(126, 32)); while (b == "\"" || b == "\\");
               send_item(1'b0, b);
            end
            3: send_item(1'b0, 8'($urandom_range(255, 128)));
            4, 5: begin
               send_item(1'b0, "\\");
               send_item(1'b0, ESC_SET[8*$urandom_range(0, 7) +: 8]);
            end
            6, 7: begin
               case ($urandom_range(0, 3))
                  0: cp = 16'($urandom_range(16'h7F, 0));
                  1: cp = 16'($urandom_range(16'h7FF, 16'h80));
                  2: cp = 16'($urandom);
                  default: cp = 16'($urandom_range(16'hDFFF, 16'hD800));
               endcase
               send_ucode(cp, 4);
            end
            default: begin
               send_ucode(16'($urandom_range(16'hDBFF, 16'hD800)), 4);
               send_ucode(16'($urandom_range(16'hDFFF, 16'hDC00)), 4);
            end
         endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         send_item(1'b0, "\"");
      end else if (pick < 80) begin
         send_item(1'b0, 8'($urandom_range(8'h1F, 0)));
      end else if (pick < 85) begin
         do b = 8'($urandom); while (is_escape_char(b));
         send_item(1'b0, "\\");
         send_item(1'b0, b);
      end else if (pick < 90) begin
         do b = 8'($urandom); while (is_hex_char(b));
         send_ucode(16'($urandom), $urandom_range(0, 3));
         send_item(1'b0, b);
      end else if (pick < 93) begin
         send_ucode(16'($urandom), $urandom_range(0, 3));
         send_item(1'b1, 8'($urandom));
      end else if (pick < 96) begin
         send_item(1'b0, "\\");
         send_item(1'b1, 8'($urandom));
      end else begin
         send_item(1'b1, 8'($urandom));
      end
   endtask

   initial begin : stimulus
      logic paused;
      paused = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: control byte, high byte, surrogate pair, escape, closing quote,
      // end of text in each mode, bad escape, bad hex on a quote
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_ucode(16'hD800, 4);
      send_ucode(16'hDFFF, 4);
      send_item(1'b0, "\\");
      send_item(1'b0, "/");
      send_item(1'b0, "\"");
      send_item(1'b1, 8'h00);
      send_item(1'b0, "\\");
      send_item(1'b1, 8'hFF);
      send_item(1'b0, "\\");
      send_item(1'b0, "q");
      send_ucode(16'h0000, 0);
      send_item(1'b0, "\"");
      send_ucode(16'hA000, 1);
      send_item(1'b1, 8'h5A);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= STALL_AT) stall_trigger <= 1'b1;
         if (items_sent >= QUIET_FROM && items_sent < QUIET_TO) begin
            quiet <= 1'b1;
         end else if (items_sent >= QUIET_TO && !paused) begin
            // sender rests until every pending result has been drained
            paused = 1'b1;
            quiet <= 1'b0;
            wait_drained();
         end
         if ($urandom_range(0, 99) < 85) send_body();
         else send_item($urandom_range(0, 7) == 0, 8'($urandom));
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fail_count == 0 && open_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
